### rtl/asmt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// asmt_pkg: shared types and constants of the altitude thrust core
// Field widths, register indexes and reset values, and the payload records
// that ride along the two pipelined dividers.
// ---------------------------------------------------------------------------
package asmt_pkg;

  // field widths
  localparam int VAL_W     = 32;
  localparam int COS_W     = 18;
  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 3;
  localparam int THRUST_W  = 21;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASS         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIMB_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY     = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0] MASS_RST         = 23'd65536;
  localparam logic [CFG_W-1:0] HEIGHT_GAIN_RST  = 23'd196608;
  localparam logic [CFG_W-1:0] CLIMB_LIMIT_RST  = 23'd262144;
  localparam logic [CFG_W-1:0] SURFACE_GAIN_RST = 23'd327680;
  localparam logic [CFG_W-1:0] SWITCH_GAIN_RST  = 23'd196608;
  localparam logic [CFG_W-1:0] BOUNDARY_RST     = 23'd9830;

  // how the switching term is formed
  typedef enum logic [1:0] {
    SW_POS,
    SW_NEG,
    SW_ZERO,
    SW_DIV
  } sw_mode_t;

  // travels with the boundary layer divider
  typedef struct packed {
    logic signed [VAL_W-1:0] lin;
    sw_mode_t                mode;
    logic                    neg;
    logic signed [COS_W-1:0] ct;
  } sw_pay_t;

  // travels with the tilt divider
  typedef struct packed {
    logic zero;
    logic over;
  } thr_flags_t;

endpackage
`default_nettype wire

### rtl/asmt_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// asmt_div: pipelined restoring divider
// Unsigned num / den, one quotient bit per register stage. The caller
// guarantees the quotient fits QUO_W bits. A side payload travels along.
// ---------------------------------------------------------------------------
module asmt_div #(
  parameter int NUM_W = 39,
  parameter int DEN_W = 23,
  parameter int QUO_W = 17,
  parameter int PAY_W = 8
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  input  wire  [NUM_W-1:0] in_num,
  input  wire  [DEN_W-1:0] in_den,
  input  wire  [PAY_W-1:0] in_pay,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output logic [PAY_W-1:0] out_pay
);

  logic [QUO_W-1:0] vld_r;
  logic [DEN_W-1:0] rem_r [QUO_W-1];
  logic [QUO_W-1:0] acc_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [PAY_W-1:0] pay_r [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    logic             vld_in;
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] acc_in;
    logic [DEN_W-1:0] den_in;
    logic [PAY_W-1:0] pay_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    // stage inputs: ports for the first step, previous stage after that
    if (i == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = DEN_W'(in_num[NUM_W-1:QUO_W]);
      assign acc_in = in_num[QUO_W-1:0];
      assign den_in = in_den;
      assign pay_in = in_pay;
    end else begin : g_next
      assign vld_in = vld_r[i-1];
      assign rem_in = rem_r[i-1];
      assign acc_in = acc_r[i-1];
      assign den_in = den_r[i-1];
      assign pay_in = pay_r[i-1];
    end

    // bring down one dividend bit and try the subtract
    assign trial = {rem_in, acc_in[QUO_W-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      acc_r[i] <= {acc_in[QUO_W-2:0], ge};
      den_r[i] <= den_in;
      pay_r[i] <= pay_in;
    end

    // the last step keeps no remainder
    if (i < QUO_W - 1) begin : g_rem
      logic [DEN_W-1:0] diff;
      // a taken subtract leaves less than den, so the low bits are exact
      assign diff = trial[DEN_W-1:0] - den_in;

      always_ff @(posedge clk) begin
        rem_r[i] <= ge ? diff : trial[DEN_W-1:0];
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_quo   = acc_r[QUO_W-1];
  assign out_pay   = pay_r[QUO_W-1];

endmodule
`default_nettype wire

### rtl/altitude_sliding_mode_thrust_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// altitude_sliding_mode_thrust_core: sliding mode altitude thrust controller
// Height error to clamped speed demand, sliding variable with a boundary
// layer switch, weight compensation, tilt correction and thrust clamp.
// ---------------------------------------------------------------------------
// Fully pipelined: while busy is low a new sample may start in every cycle,
// and each one yields one thrust value on out_thrust, flagged by out_valid
// for a single cycle. The pipeline holds two restoring dividers that
// resolve one quotient bit per stage: FRAC_BITS+1 stages for the boundary
// layer term and FRAC_BITS+5 stages for the tilt correction. The result
// side has no backpressure, so results must be captured in the cycle they
// appear. busy is high only during reset and in the cycle after it.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while no sample is in flight, the block does not check.
// ---------------------------------------------------------------------------
module altitude_sliding_mode_thrust_core
  import asmt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // sample transfer
  input  wire                        start,
  output logic                       busy,
  input  wire  signed [VAL_W-1:0]    in_height_now,
  input  wire  signed [VAL_W-1:0]    in_height_goal,
  input  wire  signed [VAL_W-1:0]    in_vertical_speed,
  input  wire  signed [COS_W-1:0]    in_tilt_cosine,
  // result transfer
  output logic                       out_valid,
  output logic [THRUST_W-1:0]        out_thrust,
  // register writes
  input  wire                        cfg_we,
  input  wire  [CFG_IDX_W-1:0]       cfg_index,
  input  wire  [CFG_W-1:0]           cfg_data
);

  // fixed point constants
  localparam longint ONE_L       = longint'(1) << FRAC_BITS;
  localparam longint GRAVITY_L   = (longint'(981) << FRAC_BITS) / 100;
  localparam longint COS_FLOOR_L = (longint'(3) << FRAC_BITS) / 10;
  localparam longint TMAX_L      = longint'(30) << FRAC_BITS;

  localparam int SW_W    = FRAC_BITS + 2;
  localparam int PRODH_W = CFG_W + 1 + VAL_W;
  localparam int PRODW_W = CFG_W + 1 + SW_W;
  localparam int CT_W    = (FRAC_BITS > COS_W - 1) ? FRAC_BITS : COS_W - 1;
  localparam int NUM1_W  = CFG_W + FRAC_BITS;
  localparam int QUO1_W  = FRAC_BITS + 1;
  localparam int NUM2_W  = VAL_W - 1 + FRAC_BITS;
  localparam int QUO2_W  = FRAC_BITS + 5;

  localparam logic signed [63:0]       FX_BIAS   = (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam logic signed [SW_W-1:0]   SW_ONE    = SW_W'(ONE_L);
  localparam logic signed [SW_W-1:0]   SW_MONE   = -SW_ONE;
  localparam logic signed [VAL_W-1:0]  GRAVITY   = VAL_W'(GRAVITY_L);
  localparam logic signed [VAL_W:0]    COS_FLOOR = (VAL_W + 1)'(COS_FLOOR_L);
  localparam logic [QUO2_W-1:0]        TMAX      = QUO2_W'(TMAX_L);

  // saturate to signed 32 bits
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  // drop the fraction of a product, toward zero, then saturate
  function automatic logic signed [VAL_W-1:0] fx_norm(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + (p[63] ? FX_BIAS : 64'sd0)) >>> FRAC_BITS;
    return sat32(t);
  endfunction

  // -------------------------------------------------------------------------
  // configuration registers
  // -------------------------------------------------------------------------
  logic [CFG_W-1:0] mass_r, height_gain_r, climb_limit_r;
  logic [CFG_W-1:0] surface_gain_r, switch_gain_r, boundary_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r         <= MASS_RST;
      height_gain_r  <= HEIGHT_GAIN_RST;
      climb_limit_r  <= CLIMB_LIMIT_RST;
      surface_gain_r <= SURFACE_GAIN_RST;
      switch_gain_r  <= SWITCH_GAIN_RST;
      boundary_r     <= BOUNDARY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MASS:         mass_r         <= cfg_data;
        REG_HEIGHT_GAIN:  height_gain_r  <= cfg_data;
        REG_CLIMB_LIMIT:  climb_limit_r  <= cfg_data;
        REG_SURFACE_GAIN: surface_gain_r <= cfg_data;
        REG_SWITCH_GAIN:  switch_gain_r  <= cfg_data;
        REG_BOUNDARY:     boundary_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // busy only around reset
  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r || !rst_n;

  logic in_xfer;
  assign in_xfer = start && !busy;

  // -------------------------------------------------------------------------
  // front half: error, speed demand, sliding variable
  // -------------------------------------------------------------------------
  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r, f_vld_r;

  logic signed [VAL_W-1:0]   a_err_r, a_vz_r;
  logic signed [COS_W-1:0]   a_ct_r;
  logic signed [PRODH_W-1:0] b_prod_r;
  logic signed [VAL_W-1:0]   b_vz_r;
  logic signed [COS_W-1:0]   b_ct_r;
  logic signed [VAL_W-1:0]   c_m_r, c_vz_r;
  logic signed [COS_W-1:0]   c_ct_r;
  logic signed [VAL_W-1:0]   d_vd_r, d_vz_r;
  logic signed [COS_W-1:0]   d_ct_r;
  logic signed [VAL_W-1:0]   e_s_r;
  logic signed [COS_W-1:0]   e_ct_r;
  logic signed [PRODH_W-1:0] f_prod_r;
  sw_mode_t                  f_mode_r;
  logic                      f_neg_r;
  logic [CFG_W-1:0]          f_abs_r;
  logic signed [COS_W-1:0]   f_ct_r;

  // height error
  logic signed [VAL_W:0]   a_diff;
  logic signed [VAL_W-1:0] a_err_nxt;
  assign a_diff    = (VAL_W + 1)'(in_height_now) - (VAL_W + 1)'(in_height_goal);
  assign a_err_nxt = sat32(64'(a_diff));

  // speed demand, negated and held to the climb limit
  logic signed [VAL_W-1:0] d_neg, d_lim, d_vd_nxt;
  assign d_neg = sat32(-64'(c_m_r));
  assign d_lim = $signed({9'd0, climb_limit_r});

  always_comb begin
    d_vd_nxt = d_neg;
    if (d_neg > d_lim) begin
      d_vd_nxt = d_lim;
    end
    if (d_neg < -d_lim) begin
      d_vd_nxt = -d_lim;
    end
  end

  // sliding variable
  logic signed [VAL_W-1:0] e_s_nxt;
  assign e_s_nxt = sat32(64'(d_vz_r) - 64'(d_vd_r));

  // boundary layer classification
  logic signed [VAL_W-1:0] f_eps;
  logic signed [VAL_W:0]   f_abs_wide;
  sw_mode_t                f_mode_nxt;
  assign f_eps      = $signed({9'd0, boundary_r});
  assign f_abs_wide = e_s_r[VAL_W-1] ? -(VAL_W + 1)'(e_s_r) : (VAL_W + 1)'(e_s_r);

  always_comb begin
    if (e_s_r > f_eps) begin
      f_mode_nxt = SW_POS;
    end else if (e_s_r < -f_eps) begin
      f_mode_nxt = SW_NEG;
    end else if (boundary_r == '0) begin
      f_mode_nxt = SW_ZERO;
    end else begin
      f_mode_nxt = SW_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_xfer;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_err_r  <= a_err_nxt;
    a_vz_r   <= in_vertical_speed;
    a_ct_r   <= in_tilt_cosine;
    b_prod_r <= $signed({1'b0, height_gain_r}) * a_err_r;
    b_vz_r   <= a_vz_r;
    b_ct_r   <= a_ct_r;
    c_m_r    <= fx_norm(64'(b_prod_r));
    c_vz_r   <= b_vz_r;
    c_ct_r   <= b_ct_r;
    d_vd_r   <= d_vd_nxt;
    d_vz_r   <= c_vz_r;
    d_ct_r   <= c_ct_r;
    e_s_r    <= e_s_nxt;
    e_ct_r   <= d_ct_r;
    f_prod_r <= $signed({1'b0, surface_gain_r}) * e_s_r;
    f_mode_r <= f_mode_nxt;
    f_neg_r  <= e_s_r[VAL_W-1];
    f_abs_r  <= f_abs_wide[CFG_W-1:0];
    f_ct_r   <= e_ct_r;
  end

  // -------------------------------------------------------------------------
  // boundary layer divide: |s| / eps
  // -------------------------------------------------------------------------
  sw_pay_t             d1_pay_in, d1_pay;
  logic                d1_vld;
  logic [QUO1_W-1:0]   d1_quo;

  assign d1_pay_in = '{lin:  fx_norm(64'(f_prod_r)),
                       mode: f_mode_r,
                       neg:  f_neg_r,
                       ct:   f_ct_r};

  asmt_div #(
    .NUM_W (NUM1_W),
    .DEN_W (CFG_W),
    .QUO_W (QUO1_W),
    .PAY_W ($bits(sw_pay_t))
  ) u_sw_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_vld_r),
    .in_num    ({f_abs_r, {FRAC_BITS{1'b0}}}),
    .in_den    (boundary_r),
    .in_pay    (d1_pay_in),
    .out_valid (d1_vld),
    .out_quo   (d1_quo),
    .out_pay   (d1_pay)
  );

  // -------------------------------------------------------------------------
  // back half: switch term, force, tilt floor
  // -------------------------------------------------------------------------
  logic g_vld_r, h_vld_r, i_vld_r, j_vld_r, k_vld_r;

  logic signed [SW_W-1:0]    g_sw_r;
  logic signed [VAL_W-1:0]   g_lin_r;
  logic signed [COS_W-1:0]   g_ct_r;
  logic signed [PRODW_W-1:0] h_prod_r;
  logic signed [VAL_W-1:0]   h_lin_r;
  logic signed [COS_W-1:0]   h_ct_r;
  logic signed [VAL_W-1:0]   i_inner_r;
  logic signed [COS_W-1:0]   i_ct_r;
  logic signed [PRODH_W-1:0] j_prod_mi_r, j_prod_mg_r;
  logic signed [COS_W-1:0]   j_ct_r;
  logic signed [VAL_W-1:0]   k_force_r;
  logic [CT_W-1:0]           k_ctf_r;

  // switch term select
  logic signed [SW_W-1:0] g_mag, g_sw_nxt;
  assign g_mag = $signed({1'b0, d1_quo});

  always_comb begin
    g_sw_nxt = '0;
    unique case (d1_pay.mode)
      SW_POS:  g_sw_nxt = SW_ONE;
      SW_NEG:  g_sw_nxt = SW_MONE;
      SW_ZERO: g_sw_nxt = '0;
      SW_DIV:  g_sw_nxt = d1_pay.neg ? -g_mag : g_mag;
    endcase
  end

  // tilt cosine held to the floor
  logic signed [VAL_W:0] j_ct_wide;
  logic [CT_W-1:0]       k_ctf_nxt;
  assign j_ct_wide = (VAL_W + 1)'(j_ct_r);
  assign k_ctf_nxt = (j_ct_wide < COS_FLOOR) ? CT_W'(COS_FLOOR_L) : CT_W'(j_ct_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
      j_vld_r <= 1'b0;
      k_vld_r <= 1'b0;
    end else begin
      g_vld_r <= d1_vld;
      h_vld_r <= g_vld_r;
      i_vld_r <= h_vld_r;
      j_vld_r <= i_vld_r;
      k_vld_r <= j_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    g_sw_r      <= g_sw_nxt;
    g_lin_r     <= d1_pay.lin;
    g_ct_r      <= d1_pay.ct;
    h_prod_r    <= $signed({1'b0, switch_gain_r}) * g_sw_r;
    h_lin_r     <= g_lin_r;
    h_ct_r      <= g_ct_r;
    i_inner_r   <= sat32(64'(h_lin_r) + 64'(fx_norm(64'(h_prod_r))));
    i_ct_r      <= h_ct_r;
    j_prod_mi_r <= $signed({1'b0, mass_r}) * i_inner_r;
    j_prod_mg_r <= $signed({1'b0, mass_r}) * GRAVITY;
    j_ct_r      <= i_ct_r;
    k_force_r   <= sat32(64'(fx_norm(64'(j_prod_mi_r))) + 64'(fx_norm(64'(j_prod_mg_r))));
    k_ctf_r     <= k_ctf_nxt;
  end

  // -------------------------------------------------------------------------
  // tilt divide: force / cosine, with range checks riding along
  // -------------------------------------------------------------------------
  thr_flags_t        d2_flags_in, d2_flags;
  logic              d2_vld;
  logic [QUO2_W-1:0] d2_quo;

  assign d2_flags_in = '{zero: (k_force_r[VAL_W-1] || (k_force_r == '0)),
                         over: ($signed({1'b0, k_ctf_r, 5'b0}) <= k_force_r)};

  asmt_div #(
    .NUM_W (NUM2_W),
    .DEN_W (CT_W),
    .QUO_W (QUO2_W),
    .PAY_W ($bits(thr_flags_t))
  ) u_tilt_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (k_vld_r),
    .in_num    ({k_force_r[VAL_W-2:0], {FRAC_BITS{1'b0}}}),
    .in_den    (k_ctf_r),
    .in_pay    (d2_flags_in),
    .out_valid (d2_vld),
    .out_quo   (d2_quo),
    .out_pay   (d2_flags)
  );

  // -------------------------------------------------------------------------
  // output register: clamp to 0 .. 30 N
  // -------------------------------------------------------------------------
  logic                out_valid_r;
  logic [THRUST_W-1:0] out_thrust_r;
  logic [QUO2_W-1:0]   l_full;
  logic [THRUST_W-1:0] out_thrust_nxt;

  always_comb begin
    if (d2_flags.zero) begin
      l_full = '0;
    end else if (d2_flags.over || (d2_quo > TMAX)) begin
      l_full = TMAX;
    end else begin
      l_full = d2_quo;
    end
  end

  assign out_thrust_nxt = THRUST_W'(l_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_thrust_r <= out_thrust_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_thrust = out_thrust_r;

endmodule
`default_nettype wire

### rtl/asmt_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// asmt_checker: port level checks for the altitude thrust core
// Watches reset behavior, fixed latency and the thrust range.
// ---------------------------------------------------------------------------
module asmt_checker
  import asmt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     start,
  input wire                     busy,
  input wire                     out_valid,
  input wire [THRUST_W-1:0]      out_thrust
);

  localparam int     LATENCY = 2 * FRAC_BITS + 18;
  localparam longint TMAX_L  = longint'(30) << FRAC_BITS;

  // no result in the cycle after a reset cycle
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // every started sample yields its result after the fixed latency
  a_fwd_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing at expected latency");

  // no result without a sample started the fixed latency earlier
  a_bwd_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching start");

  // thrust within 0 .. 30 N where the output width holds 30 N
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (FRAC_BITS <= 16)) |-> (out_thrust <= TMAX_L))
    else $error("thrust above 30 N");

  // not busy whenever rst_n was also high in the previous cycle
  a_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy outside reset");

endmodule

bind altitude_sliding_mode_thrust_core asmt_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_asmt_checker (.*);
`default_nettype wire

### test/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for altitude_sliding_mode_thrust_core
// Drives altitude samples through the command port, predicts untyped
// thrust in fixed point from a shadow copy of the gain registers and checks
// every strobed result in order. A short directed table comes first, then
// random phases under several register settings and sender idle rates.
// ---------------------------------------------------------------------------
module tb;
  import asmt_pkg::*;

  localparam int FRAC           = 16;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 250;
  localparam int DRAIN_CYCLES   = 2 * FRAC + 30;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DIR_ROWS       = 22;

  // indexes past the last register, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [COS_W-1:0] COS_ONE = 18'sd65536;
  localparam logic signed [COS_W-1:0] COS_NEG = -18'sd65536;

  localparam longint ONE_Q   = longint'(1) << FRAC;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  // hover thrust after reset, level tilt, no error
  localparam logic [THRUST_W-1:0] HOVER_THRUST = 21'd642908;
  localparam logic [THRUST_W-1:0] FULL_THRUST  = 21'd1966080;

  logic                    clk;
  logic                    rst_n             = 1'b0;
  logic                    start             = 1'b0;
  logic                    busy;
  logic signed [VAL_W-1:0] in_height_now     = '0;
  logic signed [VAL_W-1:0] in_height_goal    = '0;
  logic signed [VAL_W-1:0] in_vertical_speed = '0;
  logic signed [COS_W-1:0] in_tilt_cosine    = '0;
  logic                    out_valid;
  logic [THRUST_W-1:0]     out_thrust;
  logic                    cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index         = '0;
  logic [CFG_W-1:0]        cfg_data          = '0;

  // typed-in expectation rides along with the sample
  logic                    row_typed         = 1'b0;
  logic [THRUST_W-1:0]     row_thrust        = '0;

  // shadow copy of the gain registers
  logic [CFG_W-1:0] mass_r, height_gain_r, climb_limit_r;
  logic [CFG_W-1:0] surface_gain_r, switch_gain_r, boundary_r;

  logic [THRUST_W-1:0] pending_thrust [$];
  int unsigned         err_cnt   = 0;
  int unsigned         cycle_cnt = 0;

  typedef struct packed {
    logic signed [VAL_W-1:0] hn;
    logic signed [VAL_W-1:0] hg;
    logic signed [VAL_W-1:0] vz;
    logic signed [COS_W-1:0] ct;
    logic                    typed;
    logic [THRUST_W-1:0]     thrust;
  } sample_row_t;

  sample_row_t dir_rows [DIR_ROWS] = '{
    '{32'sd0, 32'sd0, 32'sd0, COS_ONE, 1'b1, HOVER_THRUST},
    '{32'sd0, 32'sd0, 32'sd0, COS_NEG, 1'b1, FULL_THRUST},
    '{32'sd0, 32'sd0, VAL_MAX, COS_ONE, 1'b1, FULL_THRUST},
    '{32'sd0, 32'sd0, VAL_MIN, COS_ONE, 1'b1, 21'd0},
    '{32'sd0, 32'sd0, 32'sd0, 18'sd0, 1'b1, FULL_THRUST},
    '{32'sd0, 32'sd0, 32'sd0, -18'sd131072, 1'b1, FULL_THRUST},
    '{VAL_MAX, VAL_MIN, 32'sd0, COS_ONE, 1'b0, '0},
    '{VAL_MIN, VAL_MAX, 32'sd0, COS_ONE, 1'b0, '0},
    '{32'sd0, 32'sd0, 32'sd9830, COS_ONE, 1'b0, '0},
    '{32'sd0, 32'sd0, -32'sd9830, COS_ONE, 1'b0, '0},
    '{32'sd0, 32'sd0, 32'sd9831, COS_ONE, 1'b0, '0},
    '{32'sd0, 32'sd0, -32'sd9831, COS_ONE, 1'b0, '0},
    '{32'sd0, 32'sd0, 32'sd4915, COS_ONE, 1'b0, '0},
    '{32'sd0, 32'sd0, -32'sd1, COS_ONE, 1'b0, '0},
    '{32'sd65536, 32'sd0, 32'sd0, COS_ONE, 1'b0, '0},
    '{32'sd0, 32'sd65536, 32'sd0, 18'sd65535, 1'b0, '0},
    '{32'sd0, 32'sd0, -32'sd30000, 18'sd19660, 1'b0, '0},
    '{32'sd0, 32'sd0, -32'sd30000, 18'sd19659, 1'b0, '0},
    '{32'sd0, 32'sd0, -32'sd30000, 18'sd19661, 1'b0, '0},
    '{32'sd0, 32'sd0, -32'sd30000, 18'sd131071, 1'b0, '0},
    '{VAL_MAX, VAL_MAX, 32'sd100000, COS_ONE, 1'b0, '0},
    '{VAL_MIN, VAL_MIN, VAL_MIN, 18'sd131071, 1'b0, '0}
  };

  altitude_sliding_mode_thrust_core #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_height_now    (in_height_now),
    .in_height_goal   (in_height_goal),
    .in_vertical_speed(in_vertical_speed),
    .in_tilt_cosine   (in_tilt_cosine),
    .out_valid        (out_valid),
    .out_thrust       (out_thrust),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---- thrust prediction in fixed point ----

  function automatic longint sat32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint q_mul(input longint a, input longint b);
    return sat32((a * b) / ONE_Q);
  endfunction

  function automatic longint q_div(input longint a, input longint b);
    return sat32((a * ONE_Q) / b);
  endfunction

  function automatic logic [THRUST_W-1:0] calc_thrust(
    input logic signed [VAL_W-1:0] hn,
    input logic signed [VAL_W-1:0] hg,
    input logic signed [VAL_W-1:0] vz,
    input logic signed [COS_W-1:0] ct_in
  );
    longint gravity, cos_floor, thrust_max, lim, eps;
    longint err, vd, s, sw, inner, net_force, ct, thr;
    logic [63:0] thr_bits;
    gravity    = (longint'(981) * ONE_Q) / 100;
    cos_floor  = (longint'(3) * ONE_Q) / 10;
    thrust_max = longint'(30) * ONE_Q;
    lim        = longint'({41'b0, climb_limit_r});
    eps        = longint'({41'b0, boundary_r});
    // speed demand from height error, clamped to the climb limit
    err = sat32(longint'(hn) - longint'(hg));
    vd  = sat32(-q_mul(longint'({41'b0, height_gain_r}), err));
    if (vd > lim) vd = lim;
    if (vd < -lim) vd = -lim;
    // sliding variable and boundary layer switch
    s = sat32(longint'(vz) - vd);
    if (s > eps) sw = ONE_Q;
    else if (s < -eps) sw = -ONE_Q;
    else if (eps == 0) sw = 0;
    else sw = q_div(s, eps);
    inner = sat32(q_mul(longint'({41'b0, surface_gain_r}), s) +
                  q_mul(longint'({41'b0, switch_gain_r}), sw));
    net_force = sat32(q_mul(longint'({41'b0, mass_r}), gravity) +
                      q_mul(longint'({41'b0, mass_r}), inner));
    // tilt correction with floored cosine, then thrust clamp
    ct = longint'(ct_in);
    if (ct < cos_floor) ct = cos_floor;
    thr = q_div(net_force, ct);
    if (thr < 0) thr = 0;
    if (thr > thrust_max) thr = thrust_max;
    thr_bits = thr;
    return thr_bits[THRUST_W-1:0];
  endfunction

  // ---- result check, expectation capture, shadow registers ----

  always @(posedge clk) begin
    if (!rst_n) begin
      mass_r         <= MASS_RST;
      height_gain_r  <= HEIGHT_GAIN_RST;
      climb_limit_r  <= CLIMB_LIMIT_RST;
      surface_gain_r <= SURFACE_GAIN_RST;
      switch_gain_r  <= SWITCH_GAIN_RST;
      boundary_r     <= BOUNDARY_RST;
    end else begin
      // result transfer
      if (out_valid) begin
        if (pending_thrust.size() == 0) begin
          $error("out_thrust: result with no expectation, actual %0d", out_thrust);
          err_cnt++;
        end else begin
          logic [THRUST_W-1:0] want;
          want = pending_thrust.pop_front();
          if (out_thrust !== want) begin
            $error("out_thrust mismatch: expected %0d actual %0d", want, out_thrust);
            err_cnt++;
          end
        end
      end
      // sample transfer
      if (start && !busy) begin
        if (row_typed)
          pending_thrust.push_back(row_thrust);
        else
          pending_thrust.push_back(calc_thrust(in_height_now, in_height_goal,
                                               in_vertical_speed, in_tilt_cosine));
      end
      // register write
      if (cfg_we) begin
        case (cfg_index)
          REG_MASS:         mass_r         <= cfg_data;
          REG_HEIGHT_GAIN:  height_gain_r  <= cfg_data;
          REG_CLIMB_LIMIT:  climb_limit_r  <= cfg_data;
          REG_SURFACE_GAIN: surface_gain_r <= cfg_data;
          REG_SWITCH_GAIN:  switch_gain_r  <= cfg_data;
          REG_BOUNDARY:     boundary_r     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---- stimulus helpers ----

  task automatic send_sample(
    input logic signed [VAL_W-1:0] hn,
    input logic signed [VAL_W-1:0] hg,
    input logic signed [VAL_W-1:0] vz,
    input logic signed [COS_W-1:0] ct,
    input logic                    typed,
    input logic [THRUST_W-1:0]     thrust
  );
    start             <= 1'b1;
    in_height_now     <= hn;
    in_height_goal    <= hg;
    in_vertical_speed <= vz;
    in_tilt_cosine    <= ct;
    row_typed         <= typed;
    row_thrust        <= thrust;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(input int pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_thrust.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_gains(
    input logic [CFG_W-1:0] m,
    input logic [CFG_W-1:0] hgain,
    input logic [CFG_W-1:0] climb,
    input logic [CFG_W-1:0] sgain,
    input logic [CFG_W-1:0] swgain,
    input logic [CFG_W-1:0] bw
  );
    write_reg(REG_MASS, m);
    write_reg(REG_HEIGHT_GAIN, hgain);
    write_reg(REG_CLIMB_LIMIT, climb);
    write_reg(REG_SURFACE_GAIN, sgain);
    write_reg(REG_SWITCH_GAIN, swgain);
    write_reg(REG_BOUNDARY, bw);
    write_reg(REG_SPARE_LO, CFG_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // log-uniform magnitude, random sign, with full-range and extreme picks
  function automatic logic signed [VAL_W-1:0] rand_val();
    int unsigned pick, k;
    logic [VAL_W-1:0] v;
    pick = $urandom_range(0, 9);
    if (pick < 3) return $urandom;
    if (pick == 3) return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    k = $urandom_range(0, 31);
    v = $urandom & ((32'h1 << k) - 32'h1);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic logic signed [COS_W-1:0] rand_cos();
    int unsigned pick;
    int c;
    logic [31:0] raw;
    pick = $urandom_range(0, 9);
    raw  = $urandom;
    if (pick < 6) c = int'($urandom_range(0, 131072)) - 65536;
    else if (pick < 8) c = 19660 + int'($urandom_range(0, 40)) - 20;
    else return raw[COS_W-1:0];
    return c[COS_W-1:0];
  endfunction

  function automatic logic [CFG_W-1:0] rand_reg();
    int unsigned pick, k;
    logic [31:0] raw;
    pick = $urandom_range(0, 9);
    raw  = $urandom;
    if (pick == 0) return '0;
    if (pick == 1) return raw[CFG_W-1:0];
    k = $urandom_range(0, CFG_W);
    raw = raw & ((32'h1 << k) - 32'h1);
    return raw[CFG_W-1:0];
  endfunction

  // ---- main sequence ----

  initial begin
    int idle_pct;
    logic signed [VAL_W-1:0] hn, hg, off;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed table under reset gains, back to back
    for (int r = 0; r < DIR_ROWS; r++)
      send_sample(dir_rows[r].hn, dir_rows[r].hg, dir_rows[r].vz, dir_rows[r].ct,
                  dir_rows[r].typed, dir_rows[r].thrust);

    // random phases, registers changed only with the pipe empty
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: load_gains(23'd1, 23'd0, 23'd0, 23'd0, 23'd0, 23'd1);
        1: load_gains(MASS_RST, rand_reg(), rand_reg(), rand_reg(), rand_reg(), 23'd0);
        2: load_gains('1, '1, '1, '1, '1, '1);
        3: load_gains(23'd6553600, 23'd6553600, 23'd6553600, 23'd6553600,
                      23'd6553600, 23'd6553600);
        4: load_gains(23'd0, rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg());
        default: load_gains(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                            rand_reg());
      endcase
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 55 : 24);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == 120) drain_results();
        hn = rand_val();
        case ($urandom_range(0, 3))
          0: hg = hn;
          1: begin
            off = $urandom & 32'h000F_FFFF;
            hg  = hn + ($urandom_range(0, 1) ? off : -off);
          end
          default: hg = rand_val();
        endcase
        send_sample(hn, hg, rand_val(), rand_cos(), 1'b0, '0);
        // every fourth stretch of forty runs with no gaps
        if ((i / 40) % 4 != 3) idle_gap(idle_pct);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
rtl/asmt_pkg.sv
rtl/asmt_div.sv
rtl/altitude_sliding_mode_thrust_core.sv
rtl/asmt_checker.sv
test/tb.sv
